// ===== rtl/sct_pkg.sv =====
// package for the script character tokenizer
// holds lexer state, token kind and error codes, the result type and character classes
// no dependencies
`timescale 1ns / 1ps

package sct_pkg;

  localparam int SCT_QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_QMARK = 3'd1,
    ST_NUM   = 3'd2,
    ST_WORD  = 3'd3,
    ST_STR   = 3'd4,
    ST_ESC   = 3'd5
  } lex_state_t;

  typedef enum logic [2:0] {
    K_PUNCT = 3'd0,
    K_FWD   = 3'd1,
    K_BACK  = 3'd2,
    K_END   = 3'd3,
    K_STR   = 3'd4,
    K_NUM   = 3'd5,
    K_WORD  = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_ESCAPE = 2'd1,
    ERR_UNTERM = 2'd2
  } err_t;

  typedef struct packed {
    kind_t      kind;
    logic       has_char;
    logic [7:0] char_value;
    logic       last;
    err_t       error;
  } tok_t;

  // up to two results written into the queue per accepted item
  typedef struct packed {
    logic wr0;
    logic wr1;
    tok_t tok0;
    tok_t tok1;
  } push_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_T      = 8'h74;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  // . + , : - * / = ( ) { } < > [ ] @ $ ! ^ ;
  function automatic logic is_punct(input logic [7:0] c);
    logic r;
    case (c)
      8'h2e, 8'h2b, 8'h2c, 8'h3a, 8'h2d, 8'h2a, 8'h2f, 8'h3d, 8'h28, 8'h29,
      8'h7b, 8'h7d, 8'h3c, 8'h3e, 8'h5b, 8'h5d, 8'h40, 8'h24, 8'h21, 8'h5e,
      8'h3b: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic tok_t mk_tok(input kind_t k, input logic h, input logic [7:0] v,
                                  input logic l, input err_t e);
    tok_t t;
    t.kind       = k;
    t.has_char   = h;
    t.char_value = v;
    t.last       = l;
    t.error      = e;
    return t;
  endfunction

endpackage

// ===== rtl/script_char_tokenizer_top.sv =====
// top level of the script character tokenizer
// joins the lexer front end (sct_front) and the result queue (sct_queue); uses sct_pkg
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  ch
//   out      output     out_valid/out_stall  token_kind has_char char_value last error
//
// one item is taken per cycle while the queue has room for two results
// an item gives zero to two results; they leave one per cycle while out_stall is low,
// through the registered queue, so items that give two results run at half rate
// reset clears the lexer state and empties the queue, no clearing pass
// in_stall rises only when the queue holds more than QUEUE_DEPTH-2 results
`timescale 1ns / 1ps

module script_char_tokenizer_top import sct_pkg::*; #(
  parameter int QUEUE_DEPTH = SCT_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] ch,
  input  logic       in_valid,
  output logic       in_stall,
  output logic [2:0] token_kind,
  output logic       has_char,
  output logic [7:0] char_value,
  output logic       last,
  output logic [1:0] error,
  output logic       out_valid,
  input  logic       out_stall
);

  push_t push;
  logic  room;
  tok_t  head;

  sct_front u_front (
    .clk      (clk),
    .rst      (rst),
    .ch       (ch),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .room     (room),
    .push     (push)
  );

  sct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign token_kind = head.kind;
  assign has_char   = head.has_char;
  assign char_value = head.char_value;
  assign last       = head.last;
  assign error      = head.error;

endmodule

// ===== rtl/sct_front.sv =====
// front end of the tokenizer: accepts characters, runs the lexer state
// and produces up to two results per item for the queue; uses sct_pkg
`timescale 1ns / 1ps

module sct_front import sct_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] ch,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       room,
  output push_t      push
);

  lex_state_t state, state_next;
  logic       dot_seen, dot_seen_next;
  logic       quote_is_double, quote_is_double_next;
  logic       escape_error, escape_error_next;

  logic accept;
  logic start_en;
  logic pre_en;
  tok_t pre_tok;
  logic st_en;
  tok_t st_tok;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  // does this character begin a new token after the current one is handled
  always_comb begin
    start_en = 1'b0;
    case (state)
      ST_QMARK: start_en = (ch != CH_GT) && (ch != CH_LT);
      ST_NUM:   start_en = !(is_digit(ch) || ((ch == CH_DOT) && !dot_seen));
      ST_WORD:  start_en = !(is_alpha(ch) || is_digit(ch));
      ST_STR:   start_en = (ch == CH_NUL);
      ST_ESC:   start_en = (ch == CH_NUL);
      default:  start_en = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_next           = state;
    dot_seen_next        = dot_seen;
    quote_is_double_next = quote_is_double;
    escape_error_next    = escape_error;
    case (state)
      ST_QMARK: state_next = ST_IDLE;
      ST_NUM: begin
        if (ch == CH_DOT && !dot_seen) dot_seen_next = 1'b1;
        else if (start_en) dot_seen_next = 1'b0;
      end
      ST_STR: begin
        if (ch == CH_NUL) begin
          escape_error_next = 1'b0;
        end else if (ch == (quote_is_double ? CH_DQUOTE : CH_SQUOTE)) begin
          escape_error_next = 1'b0;
          state_next        = ST_IDLE;
        end else if (ch == CH_BSLASH) begin
          state_next = ST_ESC;
        end
      end
      ST_ESC: begin
        if (ch == CH_NUL) begin
          escape_error_next = 1'b0;
        end else begin
          state_next = ST_STR;
          case (ch)
            CH_T, CH_N, CH_ZERO, CH_SQUOTE, CH_DQUOTE, CH_BSLASH, CH_NL: ;
            default: escape_error_next = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
    if (start_en) begin
      state_next = ST_IDLE;
      if (ch == CH_QMARK) begin
        state_next = ST_QMARK;
      end else if (is_punct(ch) || ch == CH_NUL) begin
        state_next = ST_IDLE;
      end else if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
        quote_is_double_next = (ch == CH_DQUOTE);
        escape_error_next    = 1'b0;
        state_next           = ST_STR;
      end else if (is_digit(ch)) begin
        dot_seen_next = 1'b0;
        state_next    = ST_NUM;
      end else if (is_alpha(ch)) begin
        state_next = ST_WORD;
      end
    end
  end

  // results
  always_comb begin
    pre_en  = 1'b0;
    pre_tok = mk_tok(K_PUNCT, 1'b0, CH_NUL, 1'b0, ERR_NONE);
    st_en   = 1'b0;
    st_tok  = mk_tok(K_PUNCT, 1'b0, CH_NUL, 1'b0, ERR_NONE);
    case (state)
      ST_QMARK: begin
        pre_en = 1'b1;
        if (ch == CH_GT)      pre_tok = mk_tok(K_FWD, 1'b0, CH_F, 1'b1, ERR_NONE);
        else if (ch == CH_LT) pre_tok = mk_tok(K_BACK, 1'b0, CH_B, 1'b1, ERR_NONE);
        else                  pre_tok = mk_tok(K_PUNCT, 1'b1, CH_QMARK, 1'b1, ERR_NONE);
      end
      ST_NUM: begin
        pre_en = 1'b1;
        if (start_en) pre_tok = mk_tok(K_NUM, 1'b0, CH_NUL, 1'b1, ERR_NONE);
        else          pre_tok = mk_tok(K_NUM, 1'b1, ch, 1'b0, ERR_NONE);
      end
      ST_WORD: begin
        pre_en = 1'b1;
        if (start_en) pre_tok = mk_tok(K_WORD, 1'b0, CH_NUL, 1'b1, ERR_NONE);
        else          pre_tok = mk_tok(K_WORD, 1'b1, ch, 1'b0, ERR_NONE);
      end
      ST_STR: begin
        if (ch == CH_NUL) begin
          pre_en  = 1'b1;
          pre_tok = mk_tok(K_STR, 1'b0, CH_NUL, 1'b1, ERR_UNTERM);
        end else if (ch == (quote_is_double ? CH_DQUOTE : CH_SQUOTE)) begin
          pre_en  = 1'b1;
          pre_tok = mk_tok(K_STR, 1'b0, CH_NUL, 1'b1,
                           escape_error ? ERR_ESCAPE : ERR_NONE);
        end else if (ch != CH_BSLASH) begin
          pre_en  = 1'b1;
          pre_tok = mk_tok(K_STR, 1'b1, ch, 1'b0, ERR_NONE);
        end
      end
      ST_ESC: begin
        pre_en = 1'b1;
        case (ch)
          CH_NUL:    pre_tok = mk_tok(K_STR, 1'b0, CH_NUL, 1'b1, ERR_UNTERM);
          CH_T:      pre_tok = mk_tok(K_STR, 1'b1, CH_TAB, 1'b0, ERR_NONE);
          CH_N:      pre_tok = mk_tok(K_STR, 1'b1, CH_NL, 1'b0, ERR_NONE);
          CH_ZERO:   pre_tok = mk_tok(K_STR, 1'b1, CH_NUL, 1'b0, ERR_NONE);
          CH_SQUOTE: pre_tok = mk_tok(K_STR, 1'b1, CH_SQUOTE, 1'b0, ERR_NONE);
          CH_DQUOTE: pre_tok = mk_tok(K_STR, 1'b1, CH_DQUOTE, 1'b0, ERR_NONE);
          CH_BSLASH: pre_tok = mk_tok(K_STR, 1'b1, CH_BSLASH, 1'b0, ERR_NONE);
          CH_NL:     pre_tok = mk_tok(K_STR, 1'b1, CH_NL, 1'b0, ERR_NONE);
          default:   pre_en  = 1'b0;
        endcase
      end
      default: ;
    endcase
    if (start_en) begin
      if (ch == CH_NUL) begin
        st_en  = 1'b1;
        st_tok = mk_tok(K_END, 1'b0, CH_NUL, 1'b1, ERR_NONE);
      end else if (ch == CH_QMARK) begin
        st_en = 1'b0;
      end else if (is_punct(ch)) begin
        st_en  = 1'b1;
        st_tok = mk_tok(K_PUNCT, 1'b1, ch, 1'b1, ERR_NONE);
      end else if (is_digit(ch)) begin
        st_en  = 1'b1;
        st_tok = mk_tok(K_NUM, 1'b1, ch, 1'b0, ERR_NONE);
      end else if (is_alpha(ch)) begin
        st_en  = 1'b1;
        st_tok = mk_tok(K_WORD, 1'b1, ch, 1'b0, ERR_NONE);
      end
    end
    push.wr0  = accept && (pre_en || st_en);
    push.wr1  = accept && pre_en && st_en;
    push.tok0 = pre_en ? pre_tok : st_tok;
    push.tok1 = st_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      dot_seen        <= 1'b0;
      quote_is_double <= 1'b0;
      escape_error    <= 1'b0;
    end else if (accept) begin
      state           <= state_next;
      dot_seen        <= dot_seen_next;
      quote_is_double <= quote_is_double_next;
      escape_error    <= escape_error_next;
    end
  end

endmodule

// ===== rtl/sct_queue.sv =====
// result queue of the tokenizer: takes up to two results a cycle from the
// front end, hands one a cycle out while out_stall is low; uses sct_pkg
`timescale 1ns / 1ps

module sct_queue import sct_pkg::*; #(
  parameter int DEPTH = SCT_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_stall,
  output tok_t  head
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  tok_t          mem [DEPTH];
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [AW-1:0] wr_ptr, wr_ptr_next, wr_ptr1;
  logic [CW-1:0] count, count_next;
  logic          pop;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign room      = (count <= CW'(DEPTH - 2));
  assign head      = mem[rd_ptr];
  assign wr_ptr1   = nxt(wr_ptr);

  always_comb begin
    rd_ptr_next = pop ? nxt(rd_ptr) : rd_ptr;
    if (push.wr1)      wr_ptr_next = nxt(wr_ptr1);
    else if (push.wr0) wr_ptr_next = wr_ptr1;
    else               wr_ptr_next = wr_ptr;
    count_next = count + CW'(push.wr0) + CW'(push.wr1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.wr0) mem[wr_ptr] <= push.tok0;
    if (push.wr1) mem[wr_ptr1] <= push.tok1;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count above depth");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.wr1 |-> push.wr0)
    else $error("second result written without the first");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push.wr0 |-> room)
    else $error("results written into a full queue");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && !push.wr0) |=> (count == $past(count) - 1'b1))
    else $error("queue count lost track on a read");

endmodule
